// ===== hw/rtl/amm_pkg.sv =====
// Shared types, constants and Q1.31 arithmetic helpers for the audio matrix mixer.
// Used by every module of the mixer; depends on nothing else.
`timescale 1ns / 1ps

package amm_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int MAX_CH       = 6;
	localparam int CH_IDX_W     = 3;
	localparam int MODE_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_CH_DEF    = 6;
	localparam int OUT_CH_DEF   = 6;

	localparam logic signed [SAMPLE_W-1:0] DEFAULT_GAIN = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] Q31_MAX      = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] Q31_MIN      = 32'sh8000_0000;

	localparam logic [MODE_W-1:0] MODE_MAX       = 3'd4;
	localparam logic [MODE_W-1:0] RST_OUTPUT_MODE = 3'd1;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_GAIN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 2'd2;

	typedef struct packed {
		logic                       op;
		logic signed [SAMPLE_W-1:0] in_ch0;
		logic signed [SAMPLE_W-1:0] in_ch1;
		logic signed [SAMPLE_W-1:0] in_ch2;
		logic signed [SAMPLE_W-1:0] in_ch3;
		logic signed [SAMPLE_W-1:0] in_ch4;
		logic signed [SAMPLE_W-1:0] in_ch5;
		logic [CH_IDX_W-1:0]        gain_row;
		logic [CH_IDX_W-1:0]        gain_col;
		logic signed [SAMPLE_W-1:0] gain_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_ch0;
		logic signed [SAMPLE_W-1:0] out_ch1;
		logic signed [SAMPLE_W-1:0] out_ch2;
		logic signed [SAMPLE_W-1:0] out_ch3;
		logic signed [SAMPLE_W-1:0] out_ch4;
		logic signed [SAMPLE_W-1:0] out_ch5;
		logic [CH_IDX_W-1:0]        active_outputs;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINAL,
		ST_ROUND
	} state_t;

	// Per-cycle controls broadcast from the sequencer to the lanes and merge stage.
	typedef struct packed {
		logic gain_wr;
		logic frame_load;
		logic mul_en;
		logic mul_final;
		logic acc_clr;
		logic acc_en;
		logic capture;
	} lane_ctrl_t;

	// Active output count for a speaker layout; unused codes act as the widest layout.
	function automatic logic [CH_IDX_W-1:0] mode_count(input logic [MODE_W-1:0] mode);
		logic [CH_IDX_W-1:0] n;
		unique case (mode)
			3'd0:    n = 3'd2;
			3'd1:    n = 3'd4;
			3'd2:    n = 3'd5;
			3'd3:    n = 3'd5;
			default: n = 3'd6;
		endcase
		return n;
	endfunction

	// Full product shifted down by 31 (floor), saturated to Q1.31.
	function automatic logic signed [SAMPLE_W-1:0] q31_round(
		input logic signed [2*SAMPLE_W-1:0] p
	);
		logic [SAMPLE_W:0] t;
		logic signed [SAMPLE_W-1:0] r;
		t = p[2*SAMPLE_W-1:SAMPLE_W-1];
		if (t[SAMPLE_W] != t[SAMPLE_W-1]) begin
			r = t[SAMPLE_W] ? Q31_MIN : Q31_MAX;
		end else begin
			r = t[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] q31_sat_add(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b
	);
		logic [SAMPLE_W:0] s;
		logic signed [SAMPLE_W-1:0] r;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			r = s[SAMPLE_W] ? Q31_MIN : Q31_MAX;
		end else begin
			r = s[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/amm_ctrl.sv =====
// Frame sequencer of the audio matrix mixer: steps all lanes through the inputs and strobes gain writes.
// Depends on amm_pkg for the state type and the lane control struct.
`timescale 1ns / 1ps

module amm_ctrl #(
	parameter int IN_CHANNELS = amm_pkg::IN_CH_DEF,
	localparam int IDX_W = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	input  logic                out_valid,
	input  logic                out_ready,
	output amm_pkg::lane_ctrl_t ctrl,
	output logic [IDX_W-1:0]    idx
);

	amm_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		ctrl     = '0;
		unique case (state_q)
			amm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == amm_pkg::OP_GAIN) begin
						ctrl.gain_wr = 1'b1;
					end else begin
						ctrl.frame_load = 1'b1;
						ctrl.acc_clr    = 1'b1;
						cnt_d           = '0;
						state_d         = amm_pkg::ST_MAC;
					end
				end
			end
			amm_pkg::ST_MAC: begin
				// The product of the previous input is folded in while the next one multiplies.
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = (cnt_q != '0);
				if (cnt_q == IDX_W'(IN_CHANNELS - 1)) begin
					state_d = amm_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			amm_pkg::ST_DRAIN: begin
				ctrl.acc_en = 1'b1;
				state_d     = amm_pkg::ST_FINAL;
			end
			amm_pkg::ST_FINAL: begin
				ctrl.mul_en    = 1'b1;
				ctrl.mul_final = 1'b1;
				state_d        = amm_pkg::ST_ROUND;
			end
			amm_pkg::ST_ROUND: begin
				if (!out_valid || out_ready) begin
					ctrl.capture = 1'b1;
					state_d      = amm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = amm_pkg::ST_IDLE;
			end
		endcase
	end

	assign idx = cnt_q;

endmodule

// ===== hw/rtl/amm_lane.sv =====
// One output-channel lane of the audio matrix mixer: its gain column and a MAC unit.
// Depends on amm_pkg for the control struct and Q1.31 helpers.
`timescale 1ns / 1ps

module amm_lane #(
	parameter int IN_CHANNELS = amm_pkg::IN_CH_DEF,
	parameter int LANE        = 0,
	localparam int IDX_W = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  amm_pkg::lane_ctrl_t                  ctrl,
	input  logic [IDX_W-1:0]                     idx,
	input  logic [amm_pkg::CH_IDX_W-1:0]         wr_row,
	input  logic [amm_pkg::CH_IDX_W-1:0]         wr_col,
	input  logic signed [amm_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic signed [amm_pkg::SAMPLE_W-1:0]  x_sel,
	input  logic signed [amm_pkg::SAMPLE_W-1:0]  master_gain,
	output logic signed [amm_pkg::SAMPLE_W-1:0]  res
);

	logic signed [amm_pkg::SAMPLE_W-1:0]   gain_q [IN_CHANNELS];
	logic signed [amm_pkg::SAMPLE_W-1:0]   acc_q;
	logic signed [2*amm_pkg::SAMPLE_W-1:0] prod_s1;
	logic signed [amm_pkg::SAMPLE_W-1:0]   mul_a, mul_b, prod_q31;
	logic                                  wr_hit;

	assign wr_hit = ctrl.gain_wr
		&& (wr_col == amm_pkg::CH_IDX_W'(LANE))
		&& (wr_row < amm_pkg::CH_IDX_W'(IN_CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IN_CHANNELS; i++) begin
				gain_q[i] <= amm_pkg::DEFAULT_GAIN;
			end
		end else if (wr_hit) begin
			gain_q[wr_row[IDX_W-1:0]] <= wr_data;
		end
	end

	// The last multiply of a frame scales the column sum by the master gain.
	assign mul_a    = ctrl.mul_final ? acc_q : gain_q[idx];
	assign mul_b    = ctrl.mul_final ? master_gain : x_sel;
	assign prod_q31 = amm_pkg::q31_round(prod_s1);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= amm_pkg::q31_sat_add(acc_q, prod_q31);
		end
	end

	assign res = prod_q31;

endmodule

// ===== hw/rtl/amm_merge.sv =====
// Merge stage of the audio matrix mixer: combines lane results, bypass and layout
// into the registered result transaction. Depends on amm_pkg.
`timescale 1ns / 1ps

module amm_merge #(
	parameter int IN_CHANNELS  = amm_pkg::IN_CH_DEF,
	parameter int OUT_CHANNELS = amm_pkg::OUT_CH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  amm_pkg::lane_ctrl_t                 ctrl,
	input  logic                                mix_enable,
	input  logic [amm_pkg::MODE_W-1:0]          output_mode,
	input  logic signed [amm_pkg::SAMPLE_W-1:0] lane_res [OUT_CHANNELS],
	input  logic signed [amm_pkg::SAMPLE_W-1:0] x [IN_CHANNELS],
	input  logic                                out_ready,
	output logic                                out_valid,
	output amm_pkg::out_item_t                  out_data
);

	logic [amm_pkg::MODE_W-1:0]          mode_c;
	logic [amm_pkg::CH_IDX_W-1:0]        layout_cnt, active;
	logic signed [amm_pkg::SAMPLE_W-1:0] ys [amm_pkg::MAX_CH];
	logic                                out_valid_q;
	amm_pkg::out_item_t                  out_q, out_d;

	assign mode_c     = (output_mode > amm_pkg::MODE_MAX) ? amm_pkg::MODE_MAX : output_mode;
	assign layout_cnt = amm_pkg::mode_count(mode_c);
	assign active     = (layout_cnt > amm_pkg::CH_IDX_W'(OUT_CHANNELS))
		? amm_pkg::CH_IDX_W'(OUT_CHANNELS) : layout_cnt;

	for (genvar o = 0; o < amm_pkg::MAX_CH; o++) begin : g_ch
		logic signed [amm_pkg::SAMPLE_W-1:0] mix_v, byp_v;
		if (o < OUT_CHANNELS) begin : g_mix
			assign mix_v = lane_res[o];
		end else begin : g_nomix
			assign mix_v = '0;
		end
		if (o < IN_CHANNELS) begin : g_byp
			assign byp_v = x[o];
		end else begin : g_nobyp
			assign byp_v = '0;
		end
		assign ys[o] = (amm_pkg::CH_IDX_W'(o) < active) ? (mix_enable ? mix_v : byp_v) : '0;
	end

	always_comb begin
		out_d.out_ch0        = ys[0];
		out_d.out_ch1        = ys[1];
		out_d.out_ch2        = ys[2];
		out_d.out_ch3        = ys[3];
		out_d.out_ch4        = ys[4];
		out_d.out_ch5        = ys[5];
		out_d.active_outputs = active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/audio_matrix_mixer.sv =====
// Audio matrix mixer top level: configuration registers, frame register, lanes and merge.
// Depends on amm_pkg, amm_ctrl, amm_lane and amm_merge.
`timescale 1ns / 1ps

// Mixes IN_CHANNELS Q1.31 inputs into up to OUT_CHANNELS outputs through a gain
// matrix, with one multiply-accumulate lane per output channel working in
// parallel. After a sample frame transaction is accepted, the sequencer steps
// through the inputs in ST_MAC, then passes ST_DRAIN, ST_FINAL and ST_ROUND, where
// the result is registered, and returns to ST_IDLE to accept the next transaction.
// Each lane multiplies one input per cycle, then applies the master gain, so the
// shared input sweep of the lanes sets the frame time. A frame whose result is
// ready while the previous result still waits at the output holds until that
// result is taken. A gain write transaction is taken in ST_IDLE and produces no
// result. A new transaction is accepted while the last result still waits at the
// output. The gain table resets to nearly 1.0 in every entry. The user must write
// configuration only while no frame is in flight; the block does not enforce this.
module audio_matrix_mixer #(
	parameter int IN_CHANNELS  = amm_pkg::IN_CH_DEF,
	parameter int OUT_CHANNELS = amm_pkg::OUT_CH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  amm_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output amm_pkg::out_item_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [amm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [amm_pkg::SAMPLE_W-1:0]     cfg_data
);

	localparam int IDX_W = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;

	logic                                mix_enable_q;
	logic [amm_pkg::MODE_W-1:0]          output_mode_q;
	logic signed [amm_pkg::SAMPLE_W-1:0] master_gain_q;

	amm_pkg::lane_ctrl_t                 ctrl;
	logic [IDX_W-1:0]                    idx;
	logic signed [amm_pkg::SAMPLE_W-1:0] in_x [amm_pkg::MAX_CH];
	logic signed [amm_pkg::SAMPLE_W-1:0] x_q [IN_CHANNELS];
	logic signed [amm_pkg::SAMPLE_W-1:0] x_sel;
	logic signed [amm_pkg::SAMPLE_W-1:0] lane_res [OUT_CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_enable_q  <= 1'b1;
			output_mode_q <= amm_pkg::RST_OUTPUT_MODE;
			master_gain_q <= amm_pkg::DEFAULT_GAIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				amm_pkg::REG_MIX_ENABLE:  mix_enable_q  <= cfg_data[0];
				amm_pkg::REG_OUTPUT_MODE: output_mode_q <= cfg_data[amm_pkg::MODE_W-1:0];
				amm_pkg::REG_MASTER_GAIN: master_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_x[0] = in_data.in_ch0;
	assign in_x[1] = in_data.in_ch1;
	assign in_x[2] = in_data.in_ch2;
	assign in_x[3] = in_data.in_ch3;
	assign in_x[4] = in_data.in_ch4;
	assign in_x[5] = in_data.in_ch5;

	always_ff @(posedge clk) begin
		if (ctrl.frame_load) begin
			for (int i = 0; i < IN_CHANNELS; i++) begin
				x_q[i] <= in_x[i];
			end
		end
	end

	assign x_sel = x_q[idx];

	amm_ctrl #(
		.IN_CHANNELS(IN_CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctrl     (ctrl),
		.idx      (idx)
	);

	for (genvar o = 0; o < OUT_CHANNELS; o++) begin : g_lane
		amm_lane #(
			.IN_CHANNELS(IN_CHANNELS),
			.LANE       (o)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.idx        (idx),
			.wr_row     (in_data.gain_row),
			.wr_col     (in_data.gain_col),
			.wr_data    (in_data.gain_value),
			.x_sel      (x_sel),
			.master_gain(master_gain_q),
			.res        (lane_res[o])
		);
	end

	amm_merge #(
		.IN_CHANNELS (IN_CHANNELS),
		.OUT_CHANNELS(OUT_CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.mix_enable (mix_enable_q),
		.output_mode(output_mode_q),
		.lane_res   (lane_res),
		.x          (x_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule
